[sv/ppte_pkg.sv]
package ppte_pkg;

  // Field widths of the item and result channels
  localparam int unsigned KIND_W  = 1;
  localparam int unsigned SEG_W   = 6;
  localparam int unsigned AXIS_W  = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned ORDER_W = 3;

  // Number of axes per segment
  localparam int unsigned AXES = 3;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_EVAL  = 1'b1;

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Derivative order after reset
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              wr;       // write transfer on the item channel
    logic              capture;  // evaluate transfer: latch segment and time
    logic              rd;       // read one coefficient
    logic [AXIS_W-1:0] axis;     // axis under evaluation
    logic [IDX_W-1:0]  idx;      // coefficient index to read or finish
    logic              load;     // accumulator takes the read coefficient
    logic              mul;      // product register takes acc * t
    logic              add;      // accumulator takes rescaled product plus coefficient
    logic              publish;  // result registers go to the output register
  } ppte_cmd_t;

endpackage

[sv/ppte_if.sv]
interface ppte_item_if;
  import ppte_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [SEG_W-1:0]         segment;
  logic [AXIS_W-1:0]        axis;
  logic [IDX_W-1:0]         coeff_index;
  logic signed [COEF_W-1:0] coeff_value;
  logic [TIME_W-1:0]        sample_time;

  modport source (output valid, kind, segment, axis, coeff_index, coeff_value, sample_time,
                  input ready);
  modport sink   (input valid, kind, segment, axis, coeff_index, coeff_value, sample_time,
                  output ready);
endinterface

interface ppte_pos_if;
  import ppte_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] pos_x;
  logic signed [COEF_W-1:0] pos_y;
  logic signed [COEF_W-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface ppte_cfg_if;
  import ppte_pkg::*;
  logic               valid;
  logic               ready;
  logic [ORDER_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/piecewise_poly_trajectory_evaluator.sv]
// Channel   Dir  Payload                                             Transfer
// item_i    in   kind, segment, axis, coeff_index, coeff_value,      valid && ready
//                sample_time
// pos_o     out  pos_x, pos_y, pos_z                                 valid && ready
// cfg_i     in   derivative_order (data)                             valid && ready
//
// An evaluate works through the axes in turn, n being the coefficient count per
// axis: each axis reads and then loads its top coefficient, then runs n-1 Horner
// steps (multiply, then round, add and saturate) through the single read port of
// the store.
// Reset clears control state and the output register and sets derivative_order to 3;
// the store is not cleared.
// A result waits in the output register while the next item is taken; a finished
// evaluate stalls only when that register is still full.
module piecewise_poly_trajectory_evaluator import ppte_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned MAX_COEFFS   = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  ppte_item_if.sink  item_i,
  ppte_pos_if.source pos_o,
  ppte_cfg_if.sink   cfg_i
);

  ppte_cmd_t cmd;
  logic      seg_ok;

  assign cfg_i.ready = 1'b1;

  ppte_ctrl #(
    .MAX_COEFFS (MAX_COEFFS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_kind_i   (item_i.kind),
    .in_ready_o  (item_i.ready),
    .seg_ok_i    (seg_ok),
    .out_valid_o (pos_o.valid),
    .out_ready_i (pos_o.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_o       (cmd)
  );

  ppte_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_COEFFS   (MAX_COEFFS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .segment_i     (item_i.segment),
    .axis_i        (item_i.axis),
    .coeff_index_i (item_i.coeff_index),
    .coeff_value_i (item_i.coeff_value),
    .sample_time_i (item_i.sample_time),
    .seg_ok_o      (seg_ok),
    .pos_x_o       (pos_o.pos_x),
    .pos_y_o       (pos_o.pos_y),
    .pos_z_o       (pos_o.pos_z)
  );

endmodule

[sv/ppte_dp.sv]
module ppte_dp import ppte_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned MAX_COEFFS   = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppte_cmd_t                cmd_i,
  input  logic [SEG_W-1:0]         segment_i,
  input  logic [AXIS_W-1:0]        axis_i,
  input  logic [IDX_W-1:0]         coeff_index_i,
  input  logic signed [COEF_W-1:0] coeff_value_i,
  input  logic [TIME_W-1:0]        sample_time_i,
  output logic                     seg_ok_o,
  output logic signed [COEF_W-1:0] pos_x_o,
  output logic signed [COEF_W-1:0] pos_y_o,
  output logic signed [COEF_W-1:0] pos_z_o
);

  localparam int unsigned DEPTH  = MAX_SEGMENTS * AXES * MAX_COEFFS;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PROD_W = COEF_W + TIME_W + 1;
  localparam int unsigned SUM_W  = PROD_W - 16 + 2;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

  logic signed [COEF_W-1:0] mem [DEPTH];
  logic signed [COEF_W-1:0] rdata_q;
  logic [SEG_W-1:0]         seg_q;
  logic [TIME_W-1:0]        time_q;
  logic                     seg_ok_q;
  logic signed [COEF_W-1:0] acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [COEF_W-1:0] res_q [AXES];
  logic signed [COEF_W-1:0] pos_x_q, pos_y_q, pos_z_q;

  logic                     wr_ok;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic signed [PROD_W:0]   biased;
  logic signed [SUM_W-2:0]  scaled;
  logic signed [SUM_W-1:0]  sum;
  logic signed [COEF_W-1:0] sat;

  // Range checks on the incoming item
  assign seg_ok_o = (32'(segment_i) < MAX_SEGMENTS);
  assign wr_ok    = seg_ok_o && (32'(axis_i) < AXES) && (32'(coeff_index_i) < MAX_COEFFS);

  // Flat store address: (segment * 3 + axis) * MAX_COEFFS + index
  assign waddr = AW'((32'(segment_i) * AXES + 32'(axis_i)) * MAX_COEFFS
                     + 32'(coeff_index_i));
  assign raddr = AW'((32'(seg_q) * AXES + 32'(cmd_i.axis)) * MAX_COEFFS + 32'(cmd_i.idx));

  // Coefficient store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem[waddr] <= coeff_value_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[raddr];
    end
  end

  // Round half up to Q16.16, add the coefficient, saturate
  assign biased = (PROD_W+1)'(prod_q) + (PROD_W+1)'(32768);
  assign scaled = (SUM_W-1)'(biased >>> 16);
  assign sum    = SUM_W'(scaled) + SUM_W'(rdata_q);

  always_comb begin
    priority if (sum > SAT_MAX) begin
      sat = COEF_W'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      sat = COEF_W'(SAT_MIN);
    end else begin
      sat = COEF_W'(sum);
    end
  end

  // Item latch and Horner registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      seg_q    <= segment_i;
      time_q   <= sample_time_i;
      seg_ok_q <= seg_ok_o;
    end
    if (cmd_i.load) begin
      acc_q <= rdata_q;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(acc_q) * PROD_W'($signed({1'b0, time_q}));
    end
    if (cmd_i.add) begin
      acc_q <= sat;
      if (cmd_i.idx == '0) begin
        res_q[cmd_i.axis] <= sat;
      end
    end
  end

  // Output register, zero for a segment outside the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (cmd_i.publish) begin
      pos_x_q <= seg_ok_q ? res_q[0] : '0;
      pos_y_q <= seg_ok_q ? res_q[1] : '0;
      pos_z_q <= seg_ok_q ? res_q[2] : '0;
    end
  end

  assign pos_x_o = pos_x_q;
  assign pos_y_o = pos_y_q;
  assign pos_z_o = pos_z_q;

endmodule

[sv/ppte_ctrl.sv]
module ppte_ctrl import ppte_pkg::*; #(
  parameter int unsigned MAX_COEFFS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [KIND_W-1:0]  in_kind_i,
  output logic               in_ready_o,
  input  logic               seg_ok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               cfg_valid_i,
  input  logic [ORDER_W-1:0] cfg_data_i,
  output ppte_cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_ACC,
    ST_MUL,
    ST_ADD,
    ST_FINISH
  } state_e;

  state_e             state_q;
  logic [AXIS_W-1:0]  axis_q;
  logic [IDX_W-1:0]   j_q;
  logic [ORDER_W-1:0] order_q;
  logic               out_valid_q;

  logic [ORDER_W-1:0] ord_eff;
  logic [ORDER_W:0]   n_raw;
  logic [ORDER_W:0]   n_use;
  logic [IDX_W-1:0]   top_idx;
  logic               in_xfer;
  logic               out_free;

  // Coefficient count: 2 * order, order zero acting as one, capped at MAX_COEFFS
  assign ord_eff = (order_q == '0) ? ORDER_W'(1) : order_q;
  assign n_raw   = {ord_eff, 1'b0};
  assign n_use   = (32'(n_raw) > MAX_COEFFS) ? (ORDER_W+1)'(MAX_COEFFS) : n_raw;
  assign top_idx = IDX_W'(n_use - 1'b1);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Decode commands from state
  always_comb begin
    cmd_o         = '0;
    cmd_o.axis    = axis_q;
    cmd_o.idx     = (state_q == ST_LOAD_RD) ? top_idx : j_q;
    cmd_o.wr      = in_xfer && (in_kind_i == KIND_WRITE);
    cmd_o.capture = in_xfer && (in_kind_i == KIND_EVAL);
    cmd_o.rd      = (state_q == ST_LOAD_RD) || (state_q == ST_MUL);
    cmd_o.load    = (state_q == ST_LOAD_ACC);
    cmd_o.mul     = (state_q == ST_MUL);
    cmd_o.add     = (state_q == ST_ADD);
    cmd_o.publish = (state_q == ST_FINISH) && out_free;
  end

  // Sequence three axes of Horner steps, hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_X;
      j_q         <= '0;
      order_q     <= ORDER_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        order_q <= cfg_data_i;
      end
      // Raise valid on publish, drop it once the transfer is taken
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && (in_kind_i == KIND_EVAL)) begin
            axis_q  <= AXIS_X;
            state_q <= seg_ok_i ? ST_LOAD_RD : ST_FINISH;
          end
        end
        ST_LOAD_RD: begin
          state_q <= ST_LOAD_ACC;
        end
        ST_LOAD_ACC: begin
          j_q     <= top_idx - 1'b1;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (j_q == '0) begin
            if (axis_q == AXIS_Z) begin
              state_q <= ST_FINISH;
            end else begin
              axis_q  <= axis_q + 1'b1;
              state_q <= ST_LOAD_RD;
            end
          end else begin
            j_q     <= j_q - 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/testbench.sv]
module testbench;
  import ppte_pkg::*;

  localparam int unsigned SEGS       = 64;
  localparam int unsigned COEFS      = 8;
  localparam int unsigned STORE_N    = SEGS * AXES * COEFS;
  localparam int unsigned SETTLE_CYC = 60;
  localparam int unsigned PHASE_ITEMS = 150;

  localparam logic [AXIS_W-1:0] AXIS_Y   = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_BAD = 2'd3;

  localparam logic signed [COEF_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [COEF_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic [TIME_W-1:0] T_MAX  = 24'hFF_FFFF;
  localparam logic [TIME_W-1:0] T_ONE  = 24'h01_0000;
  localparam logic [TIME_W-1:0] T_HALF = 24'h00_8000;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [SEG_W-1:0]         segment;
    logic [AXIS_W-1:0]        axis;
    logic [IDX_W-1:0]         coeff_index;
    logic signed [COEF_W-1:0] coeff_value;
    logic [TIME_W-1:0]        sample_time;
  } traj_req_t;

  typedef struct {
    logic signed [COEF_W-1:0] x;
    logic signed [COEF_W-1:0] y;
    logic signed [COEF_W-1:0] z;
  } pos_t;

  logic clk_i;
  logic rst_ni;

  ppte_item_if item_bus ();
  ppte_pos_if  pos_bus ();
  ppte_cfg_if  cfg_bus ();

  piecewise_poly_trajectory_evaluator #(
    .MAX_SEGMENTS(SEGS),
    .MAX_COEFFS  (COEFS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item_bus),
    .pos_o (pos_bus),
    .cfg_i (cfg_bus)
  );

  // Shadow copy of the coefficient table and the order register
  logic signed [COEF_W-1:0] coef_tab [STORE_N];
  bit                       coef_set [STORE_N];
  logic [ORDER_W-1:0]       order_q;

  pos_t        pos_expect [$];
  int unsigned errors;
  int unsigned items_done;
  logic [SEG_W-1:0] last_seg;
  bit tx_idle_en;
  bit rx_idle_en;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Coefficients used per axis under the current order
  function automatic int unsigned coef_count();
    int unsigned n;
    n = (order_q == '0) ? 2 : 2 * order_q;
    return (n > COEFS) ? COEFS : n;
  endfunction

  function automatic int unsigned tab_addr(int unsigned seg, int unsigned ax, int unsigned j);
    return (seg * AXES + ax) * COEFS + j;
  endfunction

  // Horner evaluation of one axis: round half up to Q16.16, add, saturate
  function automatic logic signed [COEF_W-1:0] horner_axis(int unsigned base, int unsigned n,
                                                           logic [TIME_W-1:0] t);
    longint acc;
    longint prod;
    int     j;
    acc = longint'(coef_tab[base + n - 1]);
    for (j = int'(n) - 2; j >= 0; j--) begin
      prod = acc * longint'({40'd0, t});
      acc  = ((prod + 64'sd32768) >>> 16) + longint'(coef_tab[base + j]);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    end
    return acc[COEF_W-1:0];
  endfunction

  function automatic bit seg_loaded(int unsigned seg, int unsigned n);
    for (int unsigned a = 0; a < AXES; a++)
      for (int unsigned j = 0; j < n; j++)
        if (!coef_set[tab_addr(seg, a, j)]) return 1'b0;
    return 1'b1;
  endfunction

  // Update the shadow table or queue the predicted position
  function automatic void predict_item(traj_req_t r);
    pos_t        p;
    int unsigned n;
    n = coef_count();
    if (r.kind == KIND_WRITE) begin
      if (r.segment < SEGS && r.axis < AXES && r.coeff_index < COEFS) begin
        coef_tab[tab_addr(r.segment, r.axis, r.coeff_index)] = r.coeff_value;
        coef_set[tab_addr(r.segment, r.axis, r.coeff_index)] = 1'b1;
      end
    end else begin
      p.x = horner_axis(tab_addr(r.segment, AXIS_X, 0), n, r.sample_time);
      p.y = horner_axis(tab_addr(r.segment, AXIS_Y, 0), n, r.sample_time);
      p.z = horner_axis(tab_addr(r.segment, AXIS_Z, 0), n, r.sample_time);
      pos_expect = {pos_expect, p};
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(bit en);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef(bit tame);
    if (tame) return $signed(COEF_W'($urandom_range(0, 'hF_FFFF))) - 32'sh0008_0000;
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3, 4, 5: return $signed(COEF_W'($urandom_range(0, 'h7_FFFF))) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time(bit tame);
    if (tame) return TIME_W'($urandom_range(0, 'h1_FFFF));
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return T_MAX;
      2, 3:    return TIME_W'($urandom_range(0, 'h1_FFFF));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  function automatic traj_req_t write_req(logic [SEG_W-1:0] seg, logic [AXIS_W-1:0] ax,
                                          logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] v);
    traj_req_t r;
    r.kind        = KIND_WRITE;
    r.segment     = seg;
    r.axis        = ax;
    r.coeff_index = idx;
    r.coeff_value = v;
    r.sample_time = TIME_W'($urandom);
    return r;
  endfunction

  function automatic traj_req_t eval_req(logic [SEG_W-1:0] seg, logic [TIME_W-1:0] t);
    traj_req_t r;
    r.kind        = KIND_EVAL;
    r.segment     = seg;
    r.axis        = AXIS_W'($urandom);
    r.coeff_index = IDX_W'($urandom);
    r.coeff_value = $urandom;
    r.sample_time = t;
    return r;
  endfunction

  // Drive one item and hold it until the transfer
  task automatic send_item(traj_req_t r);
    int unsigned gap;
    gap = pick_gap(tx_idle_en);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid       <= 1'b1;
    item_bus.kind        <= r.kind;
    item_bus.segment     <= r.segment;
    item_bus.axis        <= r.axis;
    item_bus.coeff_index <= r.coeff_index;
    item_bus.coeff_value <= r.coeff_value;
    item_bus.sample_time <= r.sample_time;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    predict_item(r);
    if (!(r.kind == KIND_WRITE && r.axis >= AXES)) items_done++;
  endtask

  // Drop valid and let every outstanding result come back
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (pos_expect.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_order(logic [ORDER_W-1:0] v);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    order_q = v;
  endtask

  function automatic logic [SEG_W-1:0] pick_loaded(logic [SEG_W-1:0] fallback, int unsigned n);
    logic [SEG_W-1:0] s;
    repeat (16) begin
      s = SEG_W'($urandom_range(0, SEGS - 1));
      if (seg_loaded(s, n)) return s;
    end
    return fallback;
  endfunction

  // Result side: random stalls on ready
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    pos_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        pos_bus.ready <= 1'b0;
        hold--;
      end else begin
        pos_bus.ready <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 3) == 0) hold = pick_gap(1'b1);
      end
    end
  end

  task automatic check_field(string fld, logic signed [COEF_W-1:0] want,
                             logic signed [COEF_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d (%h), got %0d (%h)",
               $time, fld, want, want, got, got);
    end
  endtask

  // Compare each position transfer with the oldest prediction
  always @(posedge clk_i) begin : pos_check
    pos_t want;
    if (rst_ni && pos_bus.valid === 1'b1 && pos_bus.ready) begin
      if (pos_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected position, expected none, got %h %h %h",
                 $time, pos_bus.pos_x, pos_bus.pos_y, pos_bus.pos_z);
      end else begin
        want = pos_expect.pop_front();
        check_field("pos_x", want.x, pos_bus.pos_x);
        check_field("pos_y", want.y, pos_bus.pos_y);
        check_field("pos_z", want.z, pos_bus.pos_z);
      end
    end
  end

  // Full-scale coefficients and times, ignored axis, order zero
  task automatic test_extremes();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_order(3'd1);
    send_item(write_req(6'd0, AXIS_X, 3'd0, Q_MAX));
    send_item(write_req(6'd0, AXIS_X, 3'd1, Q_MAX));
    send_item(write_req(6'd0, AXIS_Y, 3'd0, Q_MIN));
    send_item(write_req(6'd0, AXIS_Y, 3'd1, Q_MIN));
    send_item(write_req(6'd0, AXIS_Z, 3'd0, '0));
    send_item(write_req(6'd0, AXIS_Z, 3'd1, Q_ONE));
    send_item(write_req(6'd0, AXIS_BAD, 3'd0, 32'sh5A5A_5A5A));
    send_item(eval_req(6'd0, '0));
    send_item(eval_req(6'd0, T_MAX));
    send_item(eval_req(6'd0, T_ONE));
    send_item(eval_req(6'd0, T_HALF));
    send_item(eval_req(6'd0, 24'd1));
    set_order(3'd0);
    send_item(eval_req(6'd0, T_MAX));
  endtask

  // Round half up on negative and positive products, top segment
  task automatic test_rounding();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_item(write_req(6'd63, AXIS_X, 3'd0, '0));
    send_item(write_req(6'd63, AXIS_X, 3'd1, -32'sd1));
    send_item(write_req(6'd63, AXIS_Y, 3'd0, '0));
    send_item(write_req(6'd63, AXIS_Y, 3'd1, 32'sd1));
    send_item(write_req(6'd63, AXIS_Z, 3'd0, Q_MIN));
    send_item(write_req(6'd63, AXIS_Z, 3'd1, -Q_ONE));
    send_item(eval_req(6'd63, T_HALF));
    send_item(eval_req(6'd63, 24'h01_7FFF));
    last_seg = 6'd63;
  endtask

  // Load one segment in random order, then evaluate it and others
  task automatic run_burst(int unsigned n);
    int unsigned      slot [3 * COEFS];
    int unsigned      k;
    int unsigned      r;
    int unsigned      tmp;
    bit               tame;
    logic [SEG_W-1:0] seg;
    case ($urandom_range(0, 9))
      0:       seg = '0;
      1:       seg = SEG_W'(SEGS - 1);
      default: seg = SEG_W'($urandom_range(0, SEGS - 1));
    endcase
    tame       = $urandom_range(0, 1);
    tx_idle_en = ($urandom_range(0, 4) != 0);
    rx_idle_en = ($urandom_range(0, 4) != 0);
    for (k = 0; k < 3 * n; k++) slot[k] = k;
    for (k = 3 * n - 1; k > 0; k--) begin
      r       = $urandom_range(0, k);
      tmp     = slot[k];
      slot[k] = slot[r];
      slot[r] = tmp;
    end
    for (k = 0; k < 3 * n; k++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(write_req(seg, AXIS_BAD, IDX_W'($urandom), rand_coef(1'b0)));
      send_item(write_req(seg, AXIS_W'(slot[k] / n), IDX_W'(slot[k] % n), rand_coef(tame)));
    end
    last_seg = seg;
    repeat ($urandom_range(1, 6))
      send_item(eval_req(($urandom_range(0, 2) == 0) ? pick_loaded(seg, n) : seg,
                         rand_time(tame)));
  endtask

  // Stray writes anywhere and evaluates of loaded segments
  task automatic run_noise(int unsigned n);
    logic [SEG_W-1:0] s;
    tx_idle_en = ($urandom_range(0, 3) != 0);
    s = pick_loaded(last_seg, n);
    if ($urandom_range(0, 1) == 0 || !seg_loaded(s, n))
      send_item(write_req(SEG_W'($urandom_range(0, SEGS - 1)), AXIS_W'($urandom),
                          IDX_W'($urandom), rand_coef(1'b0)));
    else
      send_item(eval_req(s, rand_time(1'b0)));
  endtask

  // One phase per order setting, the reset value first
  task automatic test_random_orders();
    logic [ORDER_W-1:0] orders [8];
    int unsigned        start;
    orders = '{3'd3, 3'd7, 3'd2, 3'd0, 3'd4, 3'd1, 3'd5, 3'd6};
    foreach (orders[i]) begin
      set_order(orders[i]);
      start = items_done;
      while (items_done - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) run_burst(coef_count());
        else repeat (4) run_noise(coef_count());
      end
    end
  endtask

  initial begin
    errors     = 0;
    items_done = 0;
    last_seg   = '0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    order_q    = ORDER_RESET;
    foreach (coef_set[i]) begin
      coef_set[i] = 1'b0;
      coef_tab[i] = '0;
    end
    item_bus.valid       <= 1'b0;
    item_bus.kind        <= KIND_WRITE;
    item_bus.segment     <= '0;
    item_bus.axis        <= AXIS_X;
    item_bus.coeff_index <= '0;
    item_bus.coeff_value <= '0;
    item_bus.sample_time <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.data         <= ORDER_RESET;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_rounding();
    test_random_orders();
    settle();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
